// File: src/sgr_pkg.sv
package sgr_pkg;

  localparam int MAX_PENDING_DEF = 32;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_M        = 8'h6D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;

  localparam logic [7:0] SGR_BOLD    = 8'd1;
  localparam logic [7:0] SGR_FG_LO   = 8'd30;
  localparam logic [7:0] SGR_FG_HI   = 8'd37;
  localparam logic [7:0] SGR_FGB_LO  = 8'd90;
  localparam logic [7:0] SGR_FGB_HI  = 8'd97;
  localparam logic [7:0] SGR_BG_LO   = 8'd40;
  localparam logic [7:0] SGR_BG_HI   = 8'd47;
  localparam logic [7:0] SGR_BGB_LO  = 8'd100;
  localparam logic [7:0] SGR_BGB_HI  = 8'd107;

  localparam logic [4:0] FG_DEFAULT  = 5'd16;
  localparam logic [3:0] BG_WHITE    = 4'd8;
  localparam logic [3:0] BG_NONE     = 4'd9;
  localparam logic [4:0] FG_MAX      = 5'd16;

  typedef struct packed {
    logic [4:0] fg;
    logic [3:0] bg;
    logic       bold;
  } attr_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_ESC   = 3'b010,
    PH_PARAM = 3'b100
  } phase_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic exec;
    logic rep_load;
    logic tail_load;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic exec_replay;
    logic exec_tail;
    logic tail_pending;
    logic rep_at_last;
    logic slot_free;
  } stat_t;

  function automatic attr_t apply_seg(attr_t a, logic [7:0] v, logic nonempty);
    attr_t      r;
    logic [7:0] off;
    r   = a;
    off = '0;
    if (nonempty) begin
      if (v == SGR_BOLD) begin
        r.bold = 1'b1;
      end else if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
        off  = v - SGR_FG_LO;
        r.fg = {2'b00, off[2:0]};
      end else if (v >= SGR_FGB_LO && v <= SGR_FGB_HI) begin
        off  = v - SGR_FGB_LO;
        r.fg = {2'b01, off[2:0]};
      end else if (v >= SGR_BG_LO && v <= SGR_BG_HI) begin
        off  = v - SGR_BG_LO;
        r.bg = {1'b0, off[2:0]};
      end else if (v >= SGR_BGB_LO && v <= SGR_BGB_HI) begin
        r.bg = BG_NONE;
      end
    end
    return r;
  endfunction

endpackage

// File: src/sgr_ctrl.sv
module sgr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  sgr_pkg::stat_t st,
  output sgr_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_REPLAY = 4'b0100,
    S_TAIL   = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (st.exec_replay) begin
          state_next = S_REPLAY;
        end else if (st.exec_tail) begin
          state_next = S_TAIL;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REPLAY: begin
        if (st.slot_free) begin
          cmd.rep_load = 1'b1;
          if (st.rep_at_last) begin
            if (st.tail_pending) begin
              state_next = S_TAIL;
            end else begin
              cmd.finish = 1'b1;
              state_next = S_IDLE;
            end
          end
        end
      end
      S_TAIL: begin
        if (st.slot_free) begin
          cmd.tail_load = 1'b1;
          cmd.finish    = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/sgr_dp.sv
module sgr_dp #(
  parameter int MAX_PENDING = sgr_pkg::MAX_PENDING_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  sgr_pkg::cmd_t  cmd,
  output sgr_pkg::stat_t st,
  input  logic [7:0]     char_in,
  input  logic           chunk_end,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     char_out,
  output logic [4:0]     fg_index,
  output logic [3:0]     bg_index,
  output logic           bold,
  output logic           run_last
);

  localparam int CW = $clog2(MAX_PENDING + 1);
  localparam int AW = $clog2(MAX_PENDING);

  logic [7:0] mem [MAX_PENDING];
  logic [7:0] rd_data;

  sgr_pkg::phase_t phase;
  logic [CW-1:0]   cnt;
  sgr_pkg::attr_t  committed, shadow;
  logic [7:0]      seg_val;
  logic            seg_ne;
  logic            rst_form;

  logic [7:0]    cur_char;
  logic          cur_end;
  logic          tail_valid;
  logic          brk_q;
  logic [AW-1:0] rep_last;
  logic [AW-1:0] ridx, ridx_next;

  logic          is_esc, is_lb, is_digit, is_semi, is_m, full;
  logic          idle_ph, store, commit, brk, brk_sel, start_now;
  logic [CW-1:0] cnt_m1;
  logic [11:0]   seg_wide;
  logic [7:0]    seg_next;
  logic [3:0]    digit;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          out_load;

  sgr_pkg::attr_t reset_attr, chunk_attr;

  assign reset_attr = '{fg: sgr_pkg::FG_DEFAULT, bg: sgr_pkg::BG_NONE, bold: 1'b0};
  assign chunk_attr = '{fg: sgr_pkg::FG_DEFAULT, bg: sgr_pkg::BG_WHITE, bold: 1'b0};

  // byte classes
  assign is_esc   = (cur_char == sgr_pkg::CH_ESC);
  assign is_lb    = (cur_char == sgr_pkg::CH_LBRACKET);
  assign is_semi  = (cur_char == sgr_pkg::CH_SEMI);
  assign is_m     = (cur_char == sgr_pkg::CH_M);
  assign is_digit = (cur_char >= sgr_pkg::CH_ZERO) && (cur_char <= sgr_pkg::CH_NINE);
  assign full     = (cnt >= CW'(MAX_PENDING));

  assign idle_ph = !(phase == sgr_pkg::PH_ESC || phase == sgr_pkg::PH_PARAM);
  assign store   = !full && ((phase == sgr_pkg::PH_ESC && is_lb) ||
                             (phase == sgr_pkg::PH_PARAM && (is_digit || is_semi)));
  assign commit  = (phase == sgr_pkg::PH_PARAM) && is_m;
  assign brk     = !idle_ph && !store && !commit;
  assign brk_sel = cmd.exec ? brk : brk_q;

  assign cnt_m1   = cnt - CW'(1);
  // digit characters carry their value in the low nibble
  assign digit    = cur_char[3:0];
  assign seg_wide = ({4'b0, seg_val} << 3) + ({4'b0, seg_val} << 1) + {8'b0, digit};
  assign seg_next = (seg_wide > 12'd255) ? 8'hFF : seg_wide[7:0];

  // a new sequence opens on an escape unless the chunk ends with it
  assign start_now = is_esc && !cur_end &&
                     ((cmd.exec && idle_ph) || (cmd.finish && brk_sel));

  assign st.exec_replay  = brk || (store && cur_end);
  assign st.exec_tail    = (idle_ph || brk) && (!is_esc || cur_end);
  assign st.tail_pending = tail_valid;
  assign st.rep_at_last  = (ridx == rep_last);
  assign st.slot_free    = !out_valid || !out_stall;

  assign out_load = cmd.rep_load || cmd.tail_load;

  always_comb begin
    ridx_next = ridx;
    if (cmd.exec) begin
      ridx_next = '0;
    end else if (cmd.rep_load && !st.rep_at_last) begin
      ridx_next = ridx + AW'(1);
    end
  end

  assign wr_en   = (cmd.exec && store) || start_now;
  assign wr_addr = (cmd.exec && store) ? cnt[AW-1:0] : '0;

  // pending byte store, read continuously at the replay pointer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cur_char;
    end
    rd_data <= mem[ridx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= sgr_pkg::PH_IDLE;
      cnt       <= '0;
      committed <= chunk_attr;
      shadow    <= chunk_attr;
      seg_val   <= '0;
      seg_ne    <= 1'b0;
      rst_form  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        if (store) begin
          cnt <= cnt + CW'(1);
          if (phase == sgr_pkg::PH_ESC) begin
            phase <= sgr_pkg::PH_PARAM;
          end else if (is_digit) begin
            rst_form <= rst_form && (cnt == CW'(2)) && (cur_char == sgr_pkg::CH_ZERO);
            seg_val  <= seg_next;
            seg_ne   <= 1'b1;
          end else begin
            rst_form <= 1'b0;
            shadow   <= sgr_pkg::apply_seg(shadow, seg_val, seg_ne);
            seg_val  <= '0;
            seg_ne   <= 1'b0;
          end
        end else if (commit) begin
          phase     <= sgr_pkg::PH_IDLE;
          cnt       <= '0;
          committed <= rst_form ? reset_attr : sgr_pkg::apply_seg(shadow, seg_val, seg_ne);
        end
      end
      if (cmd.finish && brk_sel) begin
        phase <= sgr_pkg::PH_IDLE;
        cnt   <= '0;
      end
      if (start_now) begin
        phase    <= sgr_pkg::PH_ESC;
        cnt      <= CW'(1);
        shadow   <= committed;
        seg_val  <= '0;
        seg_ne   <= 1'b0;
        rst_form <= 1'b1;
      end
      if (cmd.finish && cur_end) begin
        phase     <= sgr_pkg::PH_IDLE;
        cnt       <= '0;
        committed <= chunk_attr;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_char <= char_in;
      cur_end  <= chunk_end;
    end
    if (cmd.exec) begin
      tail_valid <= st.exec_tail;
      brk_q      <= brk;
      rep_last   <= brk ? cnt_m1[AW-1:0] : cnt[AW-1:0];
    end
    ridx <= ridx_next;
    if (out_load) begin
      char_out <= cmd.tail_load ? cur_char : rd_data;
      fg_index <= committed.fg;
      bg_index <= committed.bg;
      bold     <= committed.bold;
      run_last <= cmd.tail_load || (!tail_valid && st.rep_at_last);
    end
  end

endmodule

// File: src/ansi_sgr_color_parser_core.sv
// terminal text filter: strips ESC [ params m colour sequences and tags each shown byte
// input channel: in_valid / in_stall with char_in and chunk_end, one byte per transfer
// output channel: out_valid / out_stall with char_out, fg_index, bg_index, bold, run_last
// each input byte gives zero or more output transfers; run_last marks the final one
// a byte is taken, decoded in the next cycle, then its results go out one per cycle while the output is not stalled
// plain byte: decoded in S_EXEC, loaded into the output register from S_TAIL, then the next byte is taken
// byte absorbed into a sequence: no output, the controller goes from S_EXEC straight back to S_IDLE
// broken, overlong or chunk-ending sequence: the pending bytes are replayed one at a time
// from S_REPLAY, as the pending store has one read port
// in_stall is high from the cycle after a transfer until the byte is done, with its last result loaded if it has any
// while out_stall is high the output register holds its transfer and further result loads wait
// reset: no sequence pending, foreground default, background white, bold off;
// chunk end returns the attributes to that state after flushing what is pending
module ansi_sgr_color_parser_core #(
  parameter int MAX_PENDING = sgr_pkg::MAX_PENDING_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_in,
  input  logic       chunk_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] char_out,
  output logic [4:0] fg_index,
  output logic [3:0] bg_index,
  output logic       bold,
  output logic       run_last
);

  sgr_pkg::cmd_t  cmd;
  sgr_pkg::stat_t st;

  sgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  sgr_dp #(
    .MAX_PENDING (MAX_PENDING)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .char_in   (char_in),
    .chunk_end (chunk_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_out  (char_out),
    .fg_index  (fg_index),
    .bg_index  (bg_index),
    .bold      (bold),
    .run_last  (run_last)
  );

endmodule

// File: src/sgr_checker.sv
module sgr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] char_out,
  input logic [4:0] fg_index,
  input logic [3:0] bg_index,
  input logic       bold,
  input logic       run_last
);

  // one byte at a time: a transfer in is always followed by a stalled cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  a_attr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fg_index <= sgr_pkg::FG_MAX) && (bg_index <= sgr_pkg::BG_NONE))
    else $error("attribute index out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(char_out) && $stable(run_last))
    else $error("stalled output transfer changed");

  a_out_attr_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(fg_index) && $stable(bg_index) && $stable(bold))
    else $error("stalled attributes changed");

endmodule

bind ansi_sgr_color_parser_core sgr_checker u_sgr_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int PEND_DEPTH  = sgr_pkg::MAX_PENDING_DEF;
  localparam int IDLE_PCT    = 27;
  localparam int HOLD_CYCLES = 120;
  localparam int RAND_ITEMS  = 250;

  typedef struct packed {
    logic [7:0] ch;
    logic [4:0] fg;
    logic [3:0] bg;
    logic       bold;
    logic       last;
  } shown_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    logic [4:0] fg;
    logic [3:0] bg;
    logic       bold;
  } text_row_t;

  typedef enum int {
    RUN_PLAIN, RUN_SGR, RUN_RESET, RUN_BROKEN, RUN_LONG, RUN_NOISE, RUN_KINDS
  } run_kind_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] char_in;
  logic       chunk_end;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] char_out;
  logic [4:0] fg_index;
  logic [3:0] bg_index;
  logic       bold;
  logic       run_last;

  ansi_sgr_color_parser_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_in   (char_in),
    .chunk_end (chunk_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_out  (char_out),
    .fg_index  (fg_index),
    .bg_index  (bg_index),
    .bold      (bold),
    .run_last  (run_last)
  );

  // predictor state
  sgr_pkg::phase_t seq_phase;
  logic [7:0]      held_chars [PEND_DEPTH];
  int              held_n;
  sgr_pkg::attr_t  live_attr;
  sgr_pkg::attr_t  draft_attr;
  int              seg_val;
  logic            seg_any;
  logic            zero_form;

  shown_t     shown_q [$];
  text_row_t  text_rows [$];
  logic [7:0] burst [$];

  bit hold_req = 1'b0;
  bit idle_on  = 1'b1;

  int n_sent;
  int n_chunks;
  int n_shown;
  int n_bad;
  int n_holds;
  int kind_seen [RUN_KINDS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("ansi_sgr_color_parser_core verification failed");
    $finish;
  end

  function automatic void show_char(logic [7:0] c);
    shown_t s;
    s = {c, live_attr.fg, live_attr.bg, live_attr.bold, 1'b0};
    shown_q.push_back(s);
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < held_n; i++) show_char(held_chars[i]);
    held_n    = 0;
    seq_phase = sgr_pkg::PH_IDLE;
  endfunction

  function automatic void take_plain(logic [7:0] c);
    if (c == sgr_pkg::CH_ESC) begin
      held_chars[0] = sgr_pkg::CH_ESC;
      held_n        = 1;
      seq_phase     = sgr_pkg::PH_ESC;
      draft_attr    = live_attr;
      seg_val       = 0;
      seg_any       = 1'b0;
      zero_form     = 1'b1;
    end else begin
      show_char(c);
    end
  endfunction

  function automatic void fold_segment();
    if (seg_any) begin
      if (seg_val == sgr_pkg::SGR_BOLD) begin
        draft_attr.bold = 1'b1;
      end else if (seg_val >= sgr_pkg::SGR_FG_LO && seg_val <= sgr_pkg::SGR_FG_HI) begin
        draft_attr.fg = 5'(seg_val - sgr_pkg::SGR_FG_LO);
      end else if (seg_val >= sgr_pkg::SGR_FGB_LO && seg_val <= sgr_pkg::SGR_FGB_HI) begin
        draft_attr.fg = 5'(seg_val - sgr_pkg::SGR_FGB_LO + 8);
      end else if (seg_val >= sgr_pkg::SGR_BG_LO && seg_val <= sgr_pkg::SGR_BG_HI) begin
        draft_attr.bg = 4'(seg_val - sgr_pkg::SGR_BG_LO);
      end else if (seg_val >= sgr_pkg::SGR_BGB_LO && seg_val <= sgr_pkg::SGR_BGB_HI) begin
        draft_attr.bg = sgr_pkg::BG_NONE;
      end
    end
    seg_val = 0;
    seg_any = 1'b0;
  endfunction

  function automatic void sgr_predict_byte(logic [7:0] c, logic last);
    int     n0;
    shown_t s;
    n0 = shown_q.size();
    case (seq_phase)
      sgr_pkg::PH_ESC: begin
        if (c == sgr_pkg::CH_LBRACKET && held_n < PEND_DEPTH) begin
          held_chars[held_n] = c;
          held_n++;
          seq_phase = sgr_pkg::PH_PARAM;
        end else begin
          flush_held();
          take_plain(c);
        end
      end
      sgr_pkg::PH_PARAM: begin
        if (c == sgr_pkg::CH_M) begin
          // closing byte is never stored, so a full store still commits
          if (zero_form) begin
            live_attr = {sgr_pkg::FG_DEFAULT, sgr_pkg::BG_NONE, 1'b0};
          end else begin
            fold_segment();
            live_attr = draft_attr;
          end
          held_n    = 0;
          seq_phase = sgr_pkg::PH_IDLE;
        end else if (c >= sgr_pkg::CH_ZERO && c <= sgr_pkg::CH_NINE &&
                     held_n < PEND_DEPTH) begin
          zero_form = zero_form && held_n == 2 && c == sgr_pkg::CH_ZERO;
          held_chars[held_n] = c;
          held_n++;
          seg_val = seg_val * 10 + (c - sgr_pkg::CH_ZERO);
          if (seg_val > 255) seg_val = 255;
          seg_any = 1'b1;
        end else if (c == sgr_pkg::CH_SEMI && held_n < PEND_DEPTH) begin
          zero_form = 1'b0;
          held_chars[held_n] = c;
          held_n++;
          fold_segment();
        end else begin
          flush_held();
          take_plain(c);
        end
      end
      default: begin
        seq_phase = sgr_pkg::PH_IDLE;
        take_plain(c);
      end
    endcase
    if (last) begin
      flush_held();
      live_attr = {sgr_pkg::FG_DEFAULT, sgr_pkg::BG_WHITE, 1'b0};
    end
    if (shown_q.size() > n0) begin
      s      = shown_q[shown_q.size() - 1];
      s.last = 1'b1;
      shown_q[shown_q.size() - 1] = s;
    end
  endfunction

  function automatic void tab_row(logic [7:0] c, logic last, logic typed,
                                  logic [4:0] fg, logic [3:0] bg, logic b);
    text_row_t r;
    r = {c, last, typed, fg, bg, b};
    text_rows.push_back(r);
  endfunction

  function automatic void push_num(int v);
    if (v >= 100) burst.push_back(8'(sgr_pkg::CH_ZERO + v / 100));
    if (v >= 10) burst.push_back(8'(sgr_pkg::CH_ZERO + (v / 10) % 10));
    burst.push_back(8'(sgr_pkg::CH_ZERO + v % 10));
  endfunction

  function automatic void push_segment();
    case ($urandom_range(9))
      0: ; // empty segment
      1: push_num(sgr_pkg::SGR_BOLD);
      2: push_num(sgr_pkg::SGR_FG_LO + $urandom_range(7));
      3: push_num(sgr_pkg::SGR_FGB_LO + $urandom_range(7));
      4: push_num(sgr_pkg::SGR_BG_LO + $urandom_range(7));
      5: push_num(sgr_pkg::SGR_BGB_LO + $urandom_range(7));
      6: push_num($urandom_range(255));
      // long digit run, value saturates when it passes 255
      7: repeat ($urandom_range(4, 7))
        burst.push_back(8'(sgr_pkg::CH_ZERO + $urandom_range(9)));
      8: begin
        burst.push_back(sgr_pkg::CH_ZERO);
        push_num(sgr_pkg::SGR_FG_LO + $urandom_range(7));
      end
      default: push_num(0);
    endcase
  endfunction

  function automatic void build_run(run_kind_t kind);
    int         n;
    logic [7:0] b;
    burst.delete();
    case (kind)
      RUN_PLAIN: repeat ($urandom_range(1, 4)) burst.push_back(8'($urandom_range(255)));
      RUN_SGR, RUN_BROKEN: begin
        burst.push_back(sgr_pkg::CH_ESC);
        burst.push_back(sgr_pkg::CH_LBRACKET);
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          if (i > 0) burst.push_back(sgr_pkg::CH_SEMI);
          push_segment();
        end
        if (kind == RUN_BROKEN) begin
          // maybe cut short, then a byte the sequence cannot take
          while (burst.size() > 1 && $urandom_range(2) == 0)
            burst.delete(burst.size() - 1);
          do begin
            b = 8'($urandom_range(255));
          end while ((b >= sgr_pkg::CH_ZERO && b <= sgr_pkg::CH_NINE) ||
                     b == sgr_pkg::CH_SEMI || b == sgr_pkg::CH_M ||
                     b == sgr_pkg::CH_LBRACKET);
          burst.push_back(b);
        end else begin
          burst.push_back(sgr_pkg::CH_M);
        end
        repeat ($urandom_range(1, 3)) burst.push_back(8'($urandom_range(255)));
      end
      RUN_RESET: begin
        burst.push_back(sgr_pkg::CH_ESC);
        burst.push_back(sgr_pkg::CH_LBRACKET);
        repeat ($urandom_range(2)) burst.push_back(sgr_pkg::CH_ZERO);
        burst.push_back(sgr_pkg::CH_M);
        repeat ($urandom_range(1, 2)) burst.push_back(8'($urandom_range(255)));
      end
      RUN_LONG: begin
        burst.push_back(sgr_pkg::CH_ESC);
        burst.push_back(sgr_pkg::CH_LBRACKET);
        repeat ($urandom_range(PEND_DEPTH - 6, PEND_DEPTH + 1))
          burst.push_back($urandom_range(4) == 0 ? sgr_pkg::CH_SEMI :
                          8'(sgr_pkg::CH_ZERO + $urandom_range(9)));
        burst.push_back(sgr_pkg::CH_M);
        burst.push_back(8'($urandom_range(255)));
      end
      default: repeat ($urandom_range(3, 8)) begin
        case ($urandom_range(5))
          0: burst.push_back(sgr_pkg::CH_ESC);
          1: burst.push_back(sgr_pkg::CH_LBRACKET);
          2: burst.push_back(8'(sgr_pkg::CH_ZERO + $urandom_range(9)));
          3: burst.push_back(sgr_pkg::CH_SEMI);
          4: burst.push_back(sgr_pkg::CH_M);
          default: burst.push_back(8'($urandom_range(255)));
        endcase
      end
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] c, input logic last);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_in   <= c;
    chunk_end <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sgr_predict_byte(c, last);
    n_sent++;
    if (last) n_chunks++;
    @(negedge clk);
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_bad++;
    end
  endfunction

  always @(posedge clk) begin : out_check
    shown_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      n_shown++;
      if (shown_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, got char %h", $time, char_out);
        n_bad++;
      end else begin
        want = shown_q.pop_front();
        check_field("char_out", want.ch, char_out);
        check_field("fg_index", want.fg, fg_index);
        check_field("bg_index", want.bg, bg_index);
        check_field("bold", want.bold, bold);
        check_field("run_last", want.last, run_last);
      end
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        n_holds++;
      end
      out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin
    run_kind_t kind;
    int        seq_no;
    int        n_rand;
    int        pick;

    rst       = 1'b1;
    in_valid  = 1'b0;
    char_in   = '0;
    chunk_end = 1'b0;
    seq_phase = sgr_pkg::PH_IDLE;
    held_n    = 0;
    live_attr = {sgr_pkg::FG_DEFAULT, sgr_pkg::BG_WHITE, 1'b0};
    draft_attr = live_attr;
    seg_val   = 0;
    seg_any   = 1'b0;
    zero_form = 1'b1;
    for (int i = 0; i < RUN_KINDS; i++) kind_seen[i] = 0;

    // plain bytes after reset and at the byte extremes
    tab_row("A",   1'b0, 1'b1, sgr_pkg::FG_DEFAULT, sgr_pkg::BG_WHITE, 1'b0);
    tab_row(8'h00, 1'b0, 1'b1, sgr_pkg::FG_DEFAULT, sgr_pkg::BG_WHITE, 1'b0);
    tab_row(8'hFF, 1'b0, 1'b1, sgr_pkg::FG_DEFAULT, sgr_pkg::BG_WHITE, 1'b0);
    // empty parameter list takes the reset form
    tab_row(sgr_pkg::CH_ESC,      1'b0, 1'b0, '0, '0, 1'b0);
    tab_row(sgr_pkg::CH_LBRACKET, 1'b0, 1'b0, '0, '0, 1'b0);
    tab_row(sgr_pkg::CH_M,        1'b0, 1'b0, '0, '0, 1'b0);
    tab_row("B", 1'b0, 1'b1, sgr_pkg::FG_DEFAULT, sgr_pkg::BG_NONE, 1'b0);
    // broken straight after the escape byte
    tab_row(sgr_pkg::CH_ESC,      1'b0, 1'b0, '0, '0, 1'b0);
    tab_row("q",                  1'b0, 1'b0, '0, '0, 1'b0);
    // bright foreground and bold
    tab_row(sgr_pkg::CH_ESC,      1'b0, 1'b0, '0, '0, 1'b0);
    tab_row(sgr_pkg::CH_LBRACKET, 1'b0, 1'b0, '0, '0, 1'b0);
    tab_row("9",                  1'b0, 1'b0, '0, '0, 1'b0);
    tab_row("7",                  1'b0, 1'b0, '0, '0, 1'b0);
    tab_row(sgr_pkg::CH_SEMI,     1'b0, 1'b0, '0, '0, 1'b0);
    tab_row("1",                  1'b0, 1'b0, '0, '0, 1'b0);
    tab_row(sgr_pkg::CH_M,        1'b0, 1'b0, '0, '0, 1'b0);
    tab_row("C", 1'b0, 1'b1, 5'd15, sgr_pkg::BG_NONE, 1'b1);
    // broken inside the parameters
    tab_row(sgr_pkg::CH_ESC,      1'b0, 1'b0, '0, '0, 1'b0);
    tab_row(sgr_pkg::CH_LBRACKET, 1'b0, 1'b0, '0, '0, 1'b0);
    tab_row("z",                  1'b0, 1'b0, '0, '0, 1'b0);
    // chunk end with a sequence pending, then attributes back to chunk defaults
    tab_row(sgr_pkg::CH_ESC,      1'b0, 1'b0, '0, '0, 1'b0);
    tab_row(sgr_pkg::CH_LBRACKET, 1'b0, 1'b0, '0, '0, 1'b0);
    tab_row("3",                  1'b1, 1'b0, '0, '0, 1'b0);
    tab_row("D", 1'b1, 1'b1, sgr_pkg::FG_DEFAULT, sgr_pkg::BG_WHITE, 1'b0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (text_rows[i]) begin
      send_byte(text_rows[i].ch, text_rows[i].last);
      if (text_rows[i].typed)
        shown_q[shown_q.size() - 1] = {text_rows[i].ch, text_rows[i].fg, text_rows[i].bg,
                                       text_rows[i].bold, 1'b1};
    end

    // random part: every kind once first, then a weighted mix led by well-formed sequences
    seq_no = 0;
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      if (seq_no < RUN_KINDS) begin
        kind = run_kind_t'(seq_no);
      end else begin
        pick = $urandom_range(99);
        if (pick < 35) kind = RUN_SGR;
        else if (pick < 50) kind = RUN_RESET;
        else if (pick < 65) kind = RUN_PLAIN;
        else if (pick < 78) kind = RUN_BROKEN;
        else if (pick < 88) kind = RUN_LONG;
        else kind = RUN_NOISE;
      end
      build_run(kind);
      kind_seen[kind]++;
      foreach (burst[i]) begin
        if (n_rand == 60) hold_req = 1'b1;
        idle_on = !(n_rand >= 130 && n_rand < 190);
        send_byte(burst[i], $urandom_range(99) < 3);
        n_rand++;
      end
      seq_no++;
    end

    in_valid <= 1'b0;
    while (shown_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d input bytes (%0d chunk ends) and %0d output transfers,",
             n_sent, n_chunks, n_shown);
    $display("%0d long hold-off; runs: %0d plain, %0d sgr, %0d reset form, %0d broken,",
             n_holds, kind_seen[RUN_PLAIN], kind_seen[RUN_SGR], kind_seen[RUN_RESET],
             kind_seen[RUN_BROKEN]);
    $display("%0d overlong, %0d noise", kind_seen[RUN_LONG], kind_seen[RUN_NOISE]);
    if (n_bad == 0) begin
      $display("ansi_sgr_color_parser_core verification clean");
    end else begin
      $display("ansi_sgr_color_parser_core verification failed");
    end
    $finish;
  end

endmodule
